@@ rtl/hbmon_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat monitor package
// Request and result types, event codes and register map shared by the
// heartbeat stall and clock monitor.
// ----------------------------------------------------------------------------
package hbmon_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CLK_W   = 7;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 3;

  // Event codes
  localparam logic [FUNC_W-1:0] FUNC_ALIVE      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_BASELINE   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TAKE_CLOCK = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TAKE_STALL = 3'd4;

  // Register map (word index taken from paddr[2])
  localparam logic REG_STALL_LIMIT = 1'b0;
  localparam logic [DATA_W-1:0] STALL_LIMIT_RESET = 32'd1000;

  // Position of HSION in the watched clock bits
  localparam int unsigned HSION_POS = 0;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] now_ms;
    logic [CLK_W-1:0]  clock_bits;
    logic [WORD_W-1:0] frame_pc;
    logic [WORD_W-1:0] frame_lr;
  } in_item_t;

  typedef struct packed {
    logic              reported;
    logic [CLK_W-1:0]  expected_clock;
    logic [CLK_W-1:0]  seen_clock;
    logic [TIME_W-1:0] stall_duration;
    logic [WORD_W-1:0] stall_pc_out;
    logic [WORD_W-1:0] stall_lr_out;
    logic              force_hsi_on;
  } out_item_t;

  // Request handed from the input stage to the event core
  typedef struct packed {
    logic     fire;
    in_item_t item;
  } core_req_t;

endpackage

@@ rtl/hbmon_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat monitor registers
// APB-style configuration port holding the stall limit.
// ----------------------------------------------------------------------------
module hbmon_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hbmon_pkg::ADDR_W-1:0]  paddr,
  input  logic [hbmon_pkg::DATA_W-1:0]  pwdata,
  output logic [hbmon_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [hbmon_pkg::TIME_W-1:0]  stall_limit
);

  logic [hbmon_pkg::DATA_W-1:0] stall_limit_r;
  logic [hbmon_pkg::DATA_W-1:0] stall_limit_nxt;
  logic                         reg_idx;
  logic                         wr_en;

  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    stall_limit_nxt = stall_limit_r;
    if (wr_en && (reg_idx == hbmon_pkg::REG_STALL_LIMIT)) begin
      stall_limit_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stall_limit_r <= hbmon_pkg::STALL_LIMIT_RESET;
    end else begin
      stall_limit_r <= stall_limit_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      hbmon_pkg::REG_STALL_LIMIT: prdata = stall_limit_r;
      default:                    prdata = '0;
    endcase
  end

  assign stall_limit = stall_limit_r;

endmodule

@@ rtl/hbmon_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat monitor event core
// Holds the monitor state, forms the result of one event and commits the
// state update when the event moves on to the result register.
// ----------------------------------------------------------------------------
module hbmon_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hbmon_pkg::core_req_t          req,
  input  logic [hbmon_pkg::TIME_W-1:0]  stall_limit,
  output hbmon_pkg::out_item_t          result
);

  logic [hbmon_pkg::TIME_W-1:0] alive_time_r,   alive_time_nxt;
  logic                         stall_active_r, stall_active_nxt;
  logic                         stall_pend_r,   stall_pend_nxt;
  logic [hbmon_pkg::TIME_W-1:0] stall_begin_r,  stall_begin_nxt;
  logic [hbmon_pkg::TIME_W-1:0] stall_len_r,    stall_len_nxt;
  logic [hbmon_pkg::WORD_W-1:0] cap_pc_r,       cap_pc_nxt;
  logic [hbmon_pkg::WORD_W-1:0] cap_lr_r,       cap_lr_nxt;
  logic [hbmon_pkg::CLK_W-1:0]  base_clk_r,     base_clk_nxt;
  logic [hbmon_pkg::CLK_W-1:0]  latch_clk_r,    latch_clk_nxt;
  logic                         clk_pend_r,     clk_pend_nxt;

  hbmon_pkg::in_item_t          it;
  logic [hbmon_pkg::TIME_W-1:0] since_alive;
  logic                         clk_changed;

  assign it          = req.item;
  assign since_alive = it.now_ms - alive_time_r;
  assign clk_changed = (base_clk_r != '0) && (it.clock_bits != base_clk_r) && !clk_pend_r;

  always_comb begin
    alive_time_nxt   = alive_time_r;
    stall_active_nxt = stall_active_r;
    stall_pend_nxt   = stall_pend_r;
    stall_begin_nxt  = stall_begin_r;
    stall_len_nxt    = stall_len_r;
    cap_pc_nxt       = cap_pc_r;
    cap_lr_nxt       = cap_lr_r;
    base_clk_nxt     = base_clk_r;
    latch_clk_nxt    = latch_clk_r;
    clk_pend_nxt     = clk_pend_r;
    result           = '0;

    case (it.func)
      hbmon_pkg::FUNC_ALIVE: begin
        alive_time_nxt = it.now_ms;
        if (clk_changed) begin
          latch_clk_nxt       = it.clock_bits;
          clk_pend_nxt        = 1'b1;
          result.force_hsi_on = !it.clock_bits[hbmon_pkg::HSION_POS];
        end
        // close an open stall
        if (stall_active_r) begin
          stall_len_nxt    = it.now_ms - stall_begin_r;
          stall_active_nxt = 1'b0;
          stall_pend_nxt   = 1'b1;
        end
      end
      hbmon_pkg::FUNC_TICK: begin
        if (!stall_active_r && !stall_pend_r && (since_alive > stall_limit)) begin
          stall_active_nxt = 1'b1;
          stall_begin_nxt  = alive_time_r;
          cap_pc_nxt       = it.frame_pc;
          cap_lr_nxt       = it.frame_lr;
        end
      end
      hbmon_pkg::FUNC_BASELINE: begin
        base_clk_nxt = it.clock_bits;
        clk_pend_nxt = 1'b0;
      end
      hbmon_pkg::FUNC_TAKE_CLOCK: begin
        if (clk_pend_r) begin
          result.reported       = 1'b1;
          result.expected_clock = base_clk_r;
          result.seen_clock     = latch_clk_r;
          base_clk_nxt          = it.clock_bits;
          clk_pend_nxt          = 1'b0;
        end
      end
      hbmon_pkg::FUNC_TAKE_STALL: begin
        if (stall_pend_r) begin
          stall_pend_nxt        = 1'b0;
          result.reported       = 1'b1;
          result.stall_duration = stall_len_r;
          result.stall_pc_out   = cap_pc_r;
          result.stall_lr_out   = cap_lr_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Commit state only for the event that moves on this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_time_r   <= '0;
      stall_active_r <= 1'b0;
      stall_pend_r   <= 1'b0;
      stall_begin_r  <= '0;
      stall_len_r    <= '0;
      cap_pc_r       <= '0;
      cap_lr_r       <= '0;
      base_clk_r     <= '0;
      latch_clk_r    <= '0;
      clk_pend_r     <= 1'b0;
    end else if (req.fire) begin
      alive_time_r   <= alive_time_nxt;
      stall_active_r <= stall_active_nxt;
      stall_pend_r   <= stall_pend_nxt;
      stall_begin_r  <= stall_begin_nxt;
      stall_len_r    <= stall_len_nxt;
      cap_pc_r       <= cap_pc_nxt;
      cap_lr_r       <= cap_lr_nxt;
      base_clk_r     <= base_clk_nxt;
      latch_clk_r    <= latch_clk_nxt;
      clk_pend_r     <= clk_pend_nxt;
    end
  end

endmodule

@@ rtl/heartbeat_stall_and_clock_monitor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat stall and clock monitor
// Event-driven health monitor: records heartbeats, captures stalls with the
// interrupted PC and LR, and latches changes of the watched clock bits.
//
// Usage:
//   in_valid/in_stall/in_item carry one event request; it is taken at an edge
//   with in_valid high and in_stall low. Every request yields exactly one
//   result on out_valid/out_stall/out_item, in request order.
//   A request passes through the input register, then the result register.
//   Throughput is one request per cycle while out_stall is low; the event
//   core is a single subtract and compare stage between the two registers.
//   When the receiver stalls, the result register holds its result and the
//   input register can still take one more; in_stall rises only once both
//   are full.
//   The cfg_ port holds the stall limit (byte address 0, reset 1000 ms);
//   write it only while no request is in flight.
//   Reset (rst_n low, synchronous) empties both registers and clears all
//   monitor state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module heartbeat_stall_and_clock_monitor_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hbmon_pkg::in_item_t           in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hbmon_pkg::out_item_t          out_item,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [hbmon_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [hbmon_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [hbmon_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  logic                         s1_valid_r, s1_valid_nxt;
  hbmon_pkg::in_item_t          s1_item_r;
  logic                         out_valid_r;
  hbmon_pkg::out_item_t         out_item_r;
  logic                         out_load;
  logic                         advance;
  logic                         in_take;
  logic [hbmon_pkg::TIME_W-1:0] stall_limit;
  hbmon_pkg::core_req_t         core_req;
  hbmon_pkg::out_item_t         core_result;

  hbmon_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .stall_limit (stall_limit)
  );

  assign out_load = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  assign core_req.fire = advance;
  assign core_req.item = s1_item_r;

  hbmon_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (core_req),
    .stall_limit (stall_limit),
    .result      (core_result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (out_load) begin
        out_valid_r <= advance;
      end
    end
  end

  // Payload registers: load the request on accept, the result on advance
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/hbmon_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat monitor checker
// Port-level checks of the heartbeat stall and clock monitor, bound to the
// top level.
// ----------------------------------------------------------------------------
module hbmon_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input hbmon_pkg::out_item_t out_item
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Reset empties the result register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A take report never carries an HSI request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.reported |-> !out_item.force_hsi_on)
    else $error("report with HSI request");

  // Without a report, every report field is zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.reported |->
      out_item.expected_clock == '0 && out_item.seen_clock == '0 &&
      out_item.stall_duration == '0 && out_item.stall_pc_out == '0 &&
      out_item.stall_lr_out == '0)
    else $error("report fields set without report");

  // Input side only stalls while a request is stuck behind a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

endmodule

bind heartbeat_stall_and_clock_monitor_top hbmon_checker u_hbmon_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat stall and clock monitor testbench
// Sends alive, tick, baseline and take requests with random gaps and random
// output stalls. The scoreboard keeps its own copy of the monitor state and
// the stall limit, works out the result of every accepted request and checks
// each result field by field, in order. The stall limit is rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned NUM_PHASES  = 6;
  localparam logic [hbmon_pkg::FUNC_W-1:0] FUNC_FIRST_UNUSED =
    hbmon_pkg::FUNC_TAKE_STALL + 1'b1;
  localparam logic [hbmon_pkg::ADDR_W-1:0] LIMIT_ADDR = {hbmon_pkg::REG_STALL_LIMIT, 2'b00};

  class monitor_scoreboard;
    logic [hbmon_pkg::DATA_W-1:0] stall_limit;
    logic [hbmon_pkg::TIME_W-1:0] alive_time;
    logic [hbmon_pkg::TIME_W-1:0] stall_begin;
    logic [hbmon_pkg::TIME_W-1:0] stall_length;
    logic [hbmon_pkg::WORD_W-1:0] captured_pc;
    logic [hbmon_pkg::WORD_W-1:0] captured_lr;
    logic [hbmon_pkg::CLK_W-1:0]  baseline_clock;
    logic [hbmon_pkg::CLK_W-1:0]  latched_clock;
    bit                           stall_active;
    bit                           stall_pending;
    bit                           clock_change_pending;
    hbmon_pkg::out_item_t         event_results[$];
    int unsigned                  mismatches;

    function new();
      stall_limit          = hbmon_pkg::STALL_LIMIT_RESET;
      alive_time           = '0;
      stall_begin          = '0;
      stall_length         = '0;
      captured_pc          = '0;
      captured_lr          = '0;
      baseline_clock       = '0;
      latched_clock        = '0;
      stall_active         = 1'b0;
      stall_pending        = 1'b0;
      clock_change_pending = 1'b0;
      mismatches           = 0;
    endfunction

    // Advance the monitor state by one accepted request and queue its result.
    function void apply_event(hbmon_pkg::in_item_t ev);
      hbmon_pkg::out_item_t         r;
      logic [hbmon_pkg::TIME_W-1:0] elapsed;
      r = '0;
      elapsed = ev.now_ms - alive_time;
      case (ev.func)
        hbmon_pkg::FUNC_ALIVE: begin
          alive_time = ev.now_ms;
          if (baseline_clock != '0 && ev.clock_bits != baseline_clock &&
              !clock_change_pending) begin
            latched_clock        = ev.clock_bits;
            clock_change_pending = 1'b1;
            r.force_hsi_on       = ~ev.clock_bits[hbmon_pkg::HSION_POS];
          end
          if (stall_active) begin
            stall_length  = ev.now_ms - stall_begin;
            stall_active  = 1'b0;
            stall_pending = 1'b1;
          end
        end
        hbmon_pkg::FUNC_TICK: begin
          if (!stall_active && !stall_pending && elapsed > stall_limit) begin
            stall_active = 1'b1;
            stall_begin  = alive_time;
            captured_pc  = ev.frame_pc;
            captured_lr  = ev.frame_lr;
          end
        end
        hbmon_pkg::FUNC_BASELINE: begin
          baseline_clock       = ev.clock_bits;
          clock_change_pending = 1'b0;
        end
        hbmon_pkg::FUNC_TAKE_CLOCK: begin
          if (clock_change_pending) begin
            r.reported           = 1'b1;
            r.expected_clock     = baseline_clock;
            r.seen_clock         = latched_clock;
            baseline_clock       = ev.clock_bits;
            clock_change_pending = 1'b0;
          end
        end
        hbmon_pkg::FUNC_TAKE_STALL: begin
          if (stall_pending) begin
            stall_pending    = 1'b0;
            r.reported       = 1'b1;
            r.stall_duration = stall_length;
            r.stall_pc_out   = captured_pc;
            r.stall_lr_out   = captured_lr;
          end
        end
        default: ;
      endcase
      event_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(hbmon_pkg::out_item_t got);
      hbmon_pkg::out_item_t want;
      if (event_results.size() == 0) begin
        $error("result with no request waiting: %h", got);
        mismatches++;
        return;
      end
      want = event_results.pop_front();
      compare_field("reported", 32'(want.reported), 32'(got.reported));
      compare_field("expected_clock", 32'(want.expected_clock), 32'(got.expected_clock));
      compare_field("seen_clock", 32'(want.seen_clock), 32'(got.seen_clock));
      compare_field("stall_duration", want.stall_duration, got.stall_duration);
      compare_field("stall_pc_out", want.stall_pc_out, got.stall_pc_out);
      compare_field("stall_lr_out", want.stall_lr_out, got.stall_lr_out);
      compare_field("force_hsi_on", 32'(want.force_hsi_on), 32'(got.force_hsi_on));
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  hbmon_pkg::in_item_t          in_item;
  logic                         out_valid;
  logic                         out_stall;
  hbmon_pkg::out_item_t         out_item;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [hbmon_pkg::ADDR_W-1:0] cfg_paddr;
  logic [hbmon_pkg::DATA_W-1:0] cfg_pwdata;
  logic [hbmon_pkg::DATA_W-1:0] cfg_prdata;
  logic                         cfg_pready;

  monitor_scoreboard            board;
  bit                           calm = 1'b1;
  bit                           hold_request = 1'b0;
  int unsigned                  hold_left = 0;
  int unsigned                  burst_left = 0;
  logic                         burst_level = 1'b0;
  int unsigned                  cycle_count = 0;
  logic [hbmon_pkg::TIME_W-1:0] tick_clock_ms = '0;

  heartbeat_stall_and_clock_monitor_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      board.check_result(out_item);
  end

  // Receiver: a long hold-off on request, else random stall bursts.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      if (burst_left == 0) begin
        burst_level = ($urandom_range(0, 9) < 3);
        burst_left  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                 : $urandom_range(5, 40);
      end
      burst_left--;
      out_stall <= burst_level;
    end
  end

  function automatic hbmon_pkg::in_item_t make_event(
    logic [hbmon_pkg::FUNC_W-1:0] func, logic [hbmon_pkg::TIME_W-1:0] now,
    logic [hbmon_pkg::CLK_W-1:0] bits, logic [hbmon_pkg::WORD_W-1:0] pc,
    logic [hbmon_pkg::WORD_W-1:0] lr);
    hbmon_pkg::in_item_t ev;
    ev.func       = func;
    ev.now_ms     = now;
    ev.clock_bits = bits;
    ev.frame_pc   = pc;
    ev.frame_lr   = lr;
    return ev;
  endfunction

  // Mostly steady heartbeats and ticks with time moving on around the limit.
  function automatic hbmon_pkg::in_item_t random_event();
    hbmon_pkg::in_item_t ev;
    int unsigned         pick;
    int unsigned         span;
    ev.frame_pc   = $urandom;
    ev.frame_lr   = $urandom;
    ev.clock_bits = 7'($urandom_range(0, 127));
    span = (board.stall_limit > 4000) ? 4000 : board.stall_limit;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      tick_clock_ms += $urandom_range(0, span / 2 + 1);
    else if (pick < 95)
      tick_clock_ms += $urandom_range(span / 2, 2 * span + 2);
    else
      tick_clock_ms = $urandom;
    ev.now_ms = tick_clock_ms;
    pick = $urandom_range(0, 99);
    if (pick < 35)      ev.func = hbmon_pkg::FUNC_ALIVE;
    else if (pick < 65) ev.func = hbmon_pkg::FUNC_TICK;
    else if (pick < 73) ev.func = hbmon_pkg::FUNC_BASELINE;
    else if (pick < 83) ev.func = hbmon_pkg::FUNC_TAKE_CLOCK;
    else if (pick < 95) ev.func = hbmon_pkg::FUNC_TAKE_STALL;
    else                ev.func = FUNC_FIRST_UNUSED + 3'($urandom_range(0, 2));
    pick = $urandom_range(0, 9);
    if (ev.func == hbmon_pkg::FUNC_ALIVE) begin
      if (pick < 6)
        ev.clock_bits = board.baseline_clock;
      else if (pick < 9)
        ev.clock_bits = board.baseline_clock ^
                        (7'd1 << $urandom_range(0, hbmon_pkg::CLK_W - 1));
    end else if (ev.func == hbmon_pkg::FUNC_BASELINE && pick == 0) begin
      ev.clock_bits = '0;
    end
    return ev;
  endfunction

  task automatic send_event(input hbmon_pkg::in_item_t ev);
    int unsigned gap;
    int unsigned pick;
    in_valid <= 1'b1;
    in_item  <= ev;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.apply_event(ev);
    pick = $urandom_range(0, 9);
    if (calm || pick < 6) gap = 0;
    else if (pick < 9)    gap = $urandom_range(1, 3);
    else                  gap = $urandom_range(8, 30);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.event_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_stall_limit(input logic [hbmon_pkg::DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= LIMIT_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    board.stall_limit = value;
    @(posedge clk);
  endtask

  initial begin
    logic [hbmon_pkg::DATA_W-1:0] limits [NUM_PHASES];
    board       = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    out_stall   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    calm = 1'b0;

    // Takes and unused codes with nothing pending.
    send_event(make_event(hbmon_pkg::FUNC_TAKE_STALL, '1, '1, '1, '1));
    send_event(make_event(hbmon_pkg::FUNC_TAKE_CLOCK, '1, '1, '1, '1));
    for (int k = 0; k < 3; k++)
      send_event(make_event(FUNC_FIRST_UNUSED + 3'(k), '1, '1, '1, '1));
    // No baseline yet: clock bits are not watched.
    send_event(make_event(hbmon_pkg::FUNC_ALIVE, '0, 7'h7F, '0, '0));
    // Elapsed equal to the limit does not capture, one more does.
    send_event(make_event(hbmon_pkg::FUNC_TICK, 32'd1000, '0, 32'h1234_5678, 32'h9ABC_DEF0));
    send_event(make_event(hbmon_pkg::FUNC_TICK, 32'd1001, '0, 32'hFFFF_FFFF, 32'h0000_0000));
    send_event(make_event(hbmon_pkg::FUNC_TICK, 32'd5000, '0, 32'h1111_1111, 32'h2222_2222));
    send_event(make_event(hbmon_pkg::FUNC_ALIVE, 32'd1500, '0, '0, '0));
    // Stall still unreported: no new capture.
    send_event(make_event(hbmon_pkg::FUNC_TICK, 32'd3600, '0, 32'h3333_3333, 32'h4444_4444));
    send_event(make_event(hbmon_pkg::FUNC_TAKE_STALL, '0, '0, '0, '0));
    // Clock change with HSION clear, then a second difference that is ignored.
    send_event(make_event(hbmon_pkg::FUNC_BASELINE, '0, 7'h7F, '0, '0));
    send_event(make_event(hbmon_pkg::FUNC_ALIVE, 32'd1600, 7'h7F, '0, '0));
    send_event(make_event(hbmon_pkg::FUNC_ALIVE, 32'd1700, 7'h7E, '0, '0));
    send_event(make_event(hbmon_pkg::FUNC_ALIVE, 32'd1800, 7'h00, '0, '0));
    send_event(make_event(hbmon_pkg::FUNC_TAKE_CLOCK, '0, 7'h01, '0, '0));
    send_event(make_event(hbmon_pkg::FUNC_ALIVE, 32'd1900, 7'h03, '0, '0));
    // Zero baseline turns monitoring off and drops the pending change.
    send_event(make_event(hbmon_pkg::FUNC_BASELINE, '0, 7'h00, '0, '0));
    send_event(make_event(hbmon_pkg::FUNC_ALIVE, 32'hFFFF_FF00, 7'h55, '0, '0));
    send_event(make_event(hbmon_pkg::FUNC_TAKE_CLOCK, '0, 7'h2A, '0, '0));
    // Elapsed time across the 32-bit wrap.
    send_event(make_event(hbmon_pkg::FUNC_TICK, 32'h0000_0100, '0,
                          32'hAAAA_AAAA, 32'h5555_5555));
    send_event(make_event(hbmon_pkg::FUNC_TICK, 32'h0000_0400, '0,
                          32'h5555_5555, 32'hAAAA_AAAA));
    send_event(make_event(hbmon_pkg::FUNC_ALIVE, 32'h0000_0010, 7'h00, '0, '0));
    send_event(make_event(hbmon_pkg::FUNC_TAKE_STALL, '0, '0, '0, '0));
    drain_results();

    limits[0] = '0;
    limits[1] = '1;
    limits[2] = $urandom_range(1, 3000);
    limits[3] = $urandom;
    limits[4] = 32'd1;
    limits[5] = $urandom_range(200, 1500);
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_stall_limit(limits[phase]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        if (phase == 2 && n == 100) begin
          // Hold the receiver off and keep offering requests until the block fills.
          calm = 1'b1;
          hold_request = 1'b1;
          repeat (30) send_event(random_event());
          calm = 1'b0;
        end
        send_event(random_event());
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.event_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/hbmon_pkg.sv
rtl/hbmon_regs.sv
rtl/hbmon_core.sv
rtl/heartbeat_stall_and_clock_monitor_top.sv
rtl/hbmon_checker.sv
tb/testbench.sv
